>>> sv/led_matrix_xy_to_index_top_assert.svh
// Assertion macros shared by the LED matrix index mapper.
// LMX_ASSERT_IMPLY checks that a condition implies another in the same cycle.
// LMX_ASSERT_PAST checks that a signal is only high when $past(src, n) of a
// source is high.
`ifndef LED_MATRIX_XY_TO_INDEX_TOP_ASSERT_SVH
`define LED_MATRIX_XY_TO_INDEX_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LMX_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lmx: implication check failed");
`define LMX_ASSERT_PAST(name, clk, rst, sig, src, n) \
   name: assert property (@(posedge clk) disable iff (rst) (sig) |-> $past(src, n)) \
      else $error("lmx: pipeline delay check failed");
`else
`define LMX_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define LMX_ASSERT_PAST(name, clk, rst, sig, src, n)
`endif
`endif

>>> sv/lmx_pkg.sv
`default_nettype none

package lmx_pkg;

   // Layout register bit positions, shared by the pixel and tile layouts.
   localparam int LAYOUT_BITS = 4;
   localparam int LAY_BOTTOM  = 0;
   localparam int LAY_RIGHT   = 1;
   localparam int LAY_COLUMNS = 2;
   localparam int LAY_ZIGZAG  = 3;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 3;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TILE_WIDTH   = 3'd0,
      CSR_TILE_HEIGHT  = 3'd1,
      CSR_TILES_ACROSS = 3'd2,
      CSR_TILES_DOWN   = 3'd3,
      CSR_PIXEL_LAYOUT = 3'd4,
      CSR_TILE_LAYOUT  = 3'd5
   } lmx_csr_type;

   // Reset values of the configuration registers.
   localparam int TILE_WIDTH_RESET   = 8;
   localparam int TILE_HEIGHT_RESET  = 8;
   localparam int TILES_ACROSS_RESET = 1;
   localparam int TILES_DOWN_RESET   = 1;
   localparam int LAYOUT_RESET       = 0;

   typedef logic [LAYOUT_BITS-1:0] lmx_layout_type;

   // Control bits that travel with each beat down the pipeline.
   typedef struct packed {
      logic valid;
      logic in_range;
   } lmx_ctl_type;

endpackage

`default_nettype wire

>>> sv/lmx_div_pipe.sv
`default_nettype none
`include "led_matrix_xy_to_index_top_assert.svh"

// Two restoring dividers side by side, one quotient bit per stage.
module lmx_div_pipe
   import lmx_pkg::*;
#(
   parameter int COORD_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lmx_ctl_type           in_ctl,
   input  logic [COORD_BITS-1:0] in_x,
   input  logic [COORD_BITS-1:0] in_y,
   input  logic [COORD_BITS-1:0] div_x,
   input  logic [COORD_BITS-1:0] div_y,
   output lmx_ctl_type           out_ctl,
   output logic [COORD_BITS-1:0] out_qx,
   output logic [COORD_BITS-1:0] out_rx,
   output logic [COORD_BITS-1:0] out_qy,
   output logic [COORD_BITS-1:0] out_ry
);

   localparam int STAGES = COORD_BITS;

   lmx_ctl_type           ctl_ff [STAGES];
   lmx_ctl_type           ctl_in [STAGES];
   logic [COORD_BITS-1:0] x_ff   [STAGES];
   logic [COORD_BITS-1:0] x_in   [STAGES];
   logic [COORD_BITS-1:0] y_ff   [STAGES];
   logic [COORD_BITS-1:0] y_in   [STAGES];
   logic [COORD_BITS-1:0] rx_ff  [STAGES];
   logic [COORD_BITS-1:0] rx_in  [STAGES];
   logic [COORD_BITS-1:0] ry_ff  [STAGES];
   logic [COORD_BITS-1:0] ry_in  [STAGES];
   logic [COORD_BITS-1:0] qx_ff  [STAGES];
   logic [COORD_BITS-1:0] qx_in  [STAGES];
   logic [COORD_BITS-1:0] qy_ff  [STAGES];
   logic [COORD_BITS-1:0] qy_in  [STAGES];

   // Each stage shifts in one dividend bit and subtracts the divisor if it fits.
   always_comb begin
      logic [COORD_BITS-1:0] rx_src;
      logic [COORD_BITS-1:0] ry_src;
      logic [COORD_BITS-1:0] qx_src;
      logic [COORD_BITS-1:0] qy_src;
      logic [COORD_BITS:0]   tx;
      logic [COORD_BITS:0]   ty;
      logic                  ge_x;
      logic                  ge_y;
      for (int k = 0; k < STAGES; k++) begin
         if (k == 0) begin
            ctl_in[k] = in_ctl;
            x_in[k]   = in_x;
            y_in[k]   = in_y;
            rx_src    = '0;
            ry_src    = '0;
            qx_src    = '0;
            qy_src    = '0;
         end else begin
            ctl_in[k] = ctl_ff[k-1];
            x_in[k]   = x_ff[k-1];
            y_in[k]   = y_ff[k-1];
            rx_src    = rx_ff[k-1];
            ry_src    = ry_ff[k-1];
            qx_src    = qx_ff[k-1];
            qy_src    = qy_ff[k-1];
         end
         tx   = {rx_src, x_in[k][STAGES-1-k]};
         ty   = {ry_src, y_in[k][STAGES-1-k]};
         ge_x = tx >= {1'b0, div_x};
         ge_y = ty >= {1'b0, div_y};
         rx_in[k] = ge_x ? COORD_BITS'(tx - {1'b0, div_x}) : tx[COORD_BITS-1:0];
         ry_in[k] = ge_y ? COORD_BITS'(ty - {1'b0, div_y}) : ty[COORD_BITS-1:0];
         qx_in[k] = qx_src;
         qy_in[k] = qy_src;
         qx_in[k][STAGES-1-k] = ge_x;
         qy_in[k][STAGES-1-k] = ge_y;
      end
   end

   // Stage registers; only the control bits are reset.
   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else begin
            ctl_ff[k] <= ctl_in[k];
         end
         x_ff[k]  <= x_in[k];
         y_ff[k]  <= y_in[k];
         rx_ff[k] <= rx_in[k];
         ry_ff[k] <= ry_in[k];
         qx_ff[k] <= qx_in[k];
         qy_ff[k] <= qy_in[k];
      end
   end

   assign out_ctl = ctl_ff[STAGES-1];
   assign out_qx  = qx_ff[STAGES-1];
   assign out_rx  = rx_ff[STAGES-1];
   assign out_qy  = qy_ff[STAGES-1];
   assign out_ry  = ry_ff[STAGES-1];

   `LMX_ASSERT_PAST(a_div_delay, clock, reset, out_ctl.valid, in_ctl.valid, STAGES)

endmodule

`default_nettype wire

>>> sv/lmx_order_pipe.sv
`default_nettype none
`include "led_matrix_xy_to_index_top_assert.svh"

// Applies the tile and pixel layouts and forms the linear tile number and
// the linear pixel offset inside the tile, in three stages.
module lmx_order_pipe
   import lmx_pkg::*;
#(
   parameter int COORD_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lmx_ctl_type             in_ctl,
   input  logic [COORD_BITS-1:0]   tile_col,
   input  logic [COORD_BITS-1:0]   tile_row,
   input  logic [COORD_BITS-1:0]   pix_col,
   input  logic [COORD_BITS-1:0]   pix_row,
   input  logic [COORD_BITS-1:0]   tile_width,
   input  logic [COORD_BITS-1:0]   tile_height,
   input  logic [COORD_BITS-1:0]   tiles_across,
   input  logic [COORD_BITS-1:0]   tiles_down,
   input  lmx_layout_type          pixel_layout,
   input  lmx_layout_type          tile_layout,
   output lmx_ctl_type             out_ctl,
   output logic [2*COORD_BITS-1:0] tile_lin,
   output logic [2*COORD_BITS-1:0] pixel_lin
);

   localparam int DW = 2 * COORD_BITS;
   localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

   // Stage A: corner flips, axis choice and zigzag parity.
   lmx_ctl_type           a_ctl_ff;
   logic [COORD_BITS-1:0] a_tmajor_ff, a_tminor_ff, a_tscale_ff;
   logic [COORD_BITS-1:0] a_pmajor_ff, a_pminor_ff, a_pscale_ff;
   logic                  a_todd_ff, a_podd_ff;
   logic [COORD_BITS-1:0] a_tmajor_in, a_tminor_in, a_tscale_in;
   logic [COORD_BITS-1:0] a_pmajor_in, a_pminor_in, a_pscale_in;
   logic                  a_todd_in, a_podd_in;

   always_comb begin
      logic [COORD_BITS-1:0] t_col_f;
      logic [COORD_BITS-1:0] t_row_f;
      logic [COORD_BITS-1:0] p_col_f;
      logic [COORD_BITS-1:0] p_row_f;
      logic [1:0]            corner;
      t_col_f = tile_layout[LAY_RIGHT] ? tiles_across - ONE - tile_col : tile_col;
      t_row_f = tile_layout[LAY_BOTTOM] ? tiles_down - ONE - tile_row : tile_row;
      if (tile_layout[LAY_COLUMNS]) begin
         a_tmajor_in = t_col_f;
         a_tminor_in = t_row_f;
         a_tscale_in = tiles_down;
      end else begin
         a_tmajor_in = t_row_f;
         a_tminor_in = t_col_f;
         a_tscale_in = tiles_across;
      end
      a_todd_in = tile_layout[LAY_ZIGZAG] & a_tmajor_in[0];

      // Odd zigzag tile lines start their pixels from the opposite corner.
      corner = {pixel_layout[LAY_RIGHT], pixel_layout[LAY_BOTTOM]} ^ {a_todd_in, a_todd_in};
      p_col_f = corner[1] ? tile_width - ONE - pix_col : pix_col;
      p_row_f = corner[0] ? tile_height - ONE - pix_row : pix_row;
      if (pixel_layout[LAY_COLUMNS]) begin
         a_pmajor_in = p_col_f;
         a_pminor_in = p_row_f;
         a_pscale_in = tile_height;
      end else begin
         a_pmajor_in = p_row_f;
         a_pminor_in = p_col_f;
         a_pscale_in = tile_width;
      end
      a_podd_in = pixel_layout[LAY_ZIGZAG] & a_pmajor_in[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
      end else begin
         a_ctl_ff <= in_ctl;
      end
      a_tmajor_ff <= a_tmajor_in;
      a_tminor_ff <= a_tminor_in;
      a_tscale_ff <= a_tscale_in;
      a_todd_ff   <= a_todd_in;
      a_pmajor_ff <= a_pmajor_in;
      a_pminor_ff <= a_pminor_in;
      a_pscale_ff <= a_pscale_in;
      a_podd_ff   <= a_podd_in;
   end

   // Stage B: line start by multiplication, position along the line.
   lmx_ctl_type           b_ctl_ff;
   logic [DW-1:0]         b_tprod_ff, b_pprod_ff, b_tprod_in, b_pprod_in;
   logic [COORD_BITS-1:0] b_tadd_ff, b_padd_ff, b_tadd_in, b_padd_in;

   always_comb begin
      b_tprod_in = DW'(a_tmajor_ff) * DW'(a_tscale_ff);
      b_pprod_in = DW'(a_pmajor_ff) * DW'(a_pscale_ff);
      b_tadd_in  = a_todd_ff ? a_tscale_ff - ONE - a_tminor_ff : a_tminor_ff;
      b_padd_in  = a_podd_ff ? a_pscale_ff - ONE - a_pminor_ff : a_pminor_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff <= '0;
      end else begin
         b_ctl_ff <= a_ctl_ff;
      end
      b_tprod_ff <= b_tprod_in;
      b_pprod_ff <= b_pprod_in;
      b_tadd_ff  <= b_tadd_in;
      b_padd_ff  <= b_padd_in;
   end

   // Stage C: linear positions.
   lmx_ctl_type   c_ctl_ff;
   logic [DW-1:0] c_tlin_ff, c_plin_ff, c_tlin_in, c_plin_in;

   assign c_tlin_in = b_tprod_ff + DW'(b_tadd_ff);
   assign c_plin_in = b_pprod_ff + DW'(b_padd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctl_ff <= '0;
      end else begin
         c_ctl_ff <= b_ctl_ff;
      end
      c_tlin_ff <= c_tlin_in;
      c_plin_ff <= c_plin_in;
   end

   assign out_ctl   = c_ctl_ff;
   assign tile_lin  = c_tlin_ff;
   assign pixel_lin = c_plin_ff;

   `LMX_ASSERT_PAST(a_order_delay, clock, reset, out_ctl.valid, in_ctl.valid, 3)

endmodule

`default_nettype wire

>>> sv/led_matrix_xy_to_index_top.sv
// A result strobes on rsp_valid once the beat taken with start has passed the input
// register, the range check, the divider stages (one per coordinate bit), the ordering
// stages and the tile-offset and result registers.
// Throughput: one coordinate per cycle; busy is low except during reset.
// Reset is synchronous: it empties the pipeline and restores the default
// configuration (8x8 tile, one tile, both layouts zero).
`default_nettype none
`include "led_matrix_xy_to_index_top_assert.svh"

module led_matrix_xy_to_index_top
   import lmx_pkg::*;
#(
   parameter int COORD_BITS = 8,
   parameter int INDEX_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [COORD_BITS-1:0]     req_pixel_x,
   input  logic [COORD_BITS-1:0]     req_pixel_y,
   output logic                      rsp_valid,
   output logic                      rsp_in_range,
   output logic [INDEX_BITS-1:0]     rsp_led_index,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]     csr_wdata
);

   localparam int DW      = 2 * COORD_BITS;
   localparam int LATENCY = COORD_BITS + 7;

   logic accept;

   assign busy      = reset;
   assign accept    = start & ~busy;
   assign csr_ready = ~reset;

   // Configuration registers.
   logic [COORD_BITS-1:0] tile_width_ff, tile_height_ff, tiles_across_ff, tiles_down_ff;
   lmx_layout_type        pixel_layout_ff, tile_layout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_width_ff   <= COORD_BITS'(TILE_WIDTH_RESET);
         tile_height_ff  <= COORD_BITS'(TILE_HEIGHT_RESET);
         tiles_across_ff <= COORD_BITS'(TILES_ACROSS_RESET);
         tiles_down_ff   <= COORD_BITS'(TILES_DOWN_RESET);
         pixel_layout_ff <= LAYOUT_BITS'(LAYOUT_RESET);
         tile_layout_ff  <= LAYOUT_BITS'(LAYOUT_RESET);
      end else if (csr_valid && csr_ready) begin
         case (lmx_csr_type'(csr_index))
            CSR_TILE_WIDTH: begin
               tile_width_ff <= csr_wdata;
            end
            CSR_TILE_HEIGHT: begin
               tile_height_ff <= csr_wdata;
            end
            CSR_TILES_ACROSS: begin
               tiles_across_ff <= csr_wdata;
            end
            CSR_TILES_DOWN: begin
               tiles_down_ff <= csr_wdata;
            end
            CSR_PIXEL_LAYOUT: begin
               pixel_layout_ff <= csr_wdata[LAYOUT_BITS-1:0];
            end
            CSR_TILE_LAYOUT: begin
               tile_layout_ff <= csr_wdata[LAYOUT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Display size and tile area, refreshed every cycle from the registers.
   logic [DW-1:0] wtot_ff, htot_ff, area_ff;

   always_ff @(posedge clock) begin
      wtot_ff <= DW'(tile_width_ff) * DW'(tiles_across_ff);
      htot_ff <= DW'(tile_height_ff) * DW'(tiles_down_ff);
      area_ff <= DW'(tile_width_ff) * DW'(tile_height_ff);
   end

   // Input register.
   logic                  s0_valid_ff;
   logic [COORD_BITS-1:0] s0_x_ff, s0_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
      s0_x_ff <= req_pixel_x;
      s0_y_ff <= req_pixel_y;
   end

   // Range check against the whole display; a zero size leaves no pixel.
   lmx_ctl_type           s1_ctl_ff, s1_ctl_in;
   logic [COORD_BITS-1:0] s1_x_ff, s1_y_ff;

   always_comb begin
      s1_ctl_in.valid    = s0_valid_ff;
      s1_ctl_in.in_range = s0_valid_ff && (DW'(s0_x_ff) < wtot_ff) && (DW'(s0_y_ff) < htot_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
      end
      s1_x_ff <= s0_x_ff;
      s1_y_ff <= s0_y_ff;
   end

   // Split coordinates into tile number and position inside the tile.
   lmx_ctl_type           d_ctl;
   logic [COORD_BITS-1:0] d_tcol, d_px, d_trow, d_py;

   lmx_div_pipe #(
      .COORD_BITS(COORD_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (s1_ctl_ff),
      .in_x    (s1_x_ff),
      .in_y    (s1_y_ff),
      .div_x   (tile_width_ff),
      .div_y   (tile_height_ff),
      .out_ctl (d_ctl),
      .out_qx  (d_tcol),
      .out_rx  (d_px),
      .out_qy  (d_trow),
      .out_ry  (d_py)
   );

   // Layout ordering of tiles and pixels.
   lmx_ctl_type   o_ctl;
   logic [DW-1:0] o_tile_lin, o_pixel_lin;

   lmx_order_pipe #(
      .COORD_BITS(COORD_BITS)
   ) u_order (
      .clock        (clock),
      .reset        (reset),
      .in_ctl       (d_ctl),
      .tile_col     (d_tcol),
      .tile_row     (d_trow),
      .pix_col      (d_px),
      .pix_row      (d_py),
      .tile_width   (tile_width_ff),
      .tile_height  (tile_height_ff),
      .tiles_across (tiles_across_ff),
      .tiles_down   (tiles_down_ff),
      .pixel_layout (pixel_layout_ff),
      .tile_layout  (tile_layout_ff),
      .out_ctl      (o_ctl),
      .tile_lin     (o_tile_lin),
      .pixel_lin    (o_pixel_lin)
   );

   // Tile offset: tile number times tile area, wrapped to the index width.
   lmx_ctl_type           m_ctl_ff;
   logic [INDEX_BITS-1:0] m_full;
   logic [INDEX_BITS-1:0] m_prod_ff, m_plin_ff;

   assign m_full = INDEX_BITS'(o_tile_lin) * INDEX_BITS'(area_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ctl_ff <= '0;
      end else begin
         m_ctl_ff <= o_ctl;
      end
      m_prod_ff <= m_full;
      m_plin_ff <= INDEX_BITS'(o_pixel_lin);
   end

   // Result register; off-display coordinates give index zero.
   lmx_ctl_type           r_ctl_ff;
   logic [INDEX_BITS-1:0] r_index_ff, r_index_in;

   assign r_index_in = m_ctl_ff.in_range ? m_prod_ff + m_plin_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ctl_ff <= '0;
      end else begin
         r_ctl_ff <= m_ctl_ff;
      end
      r_index_ff <= r_index_in;
   end

   assign rsp_valid     = r_ctl_ff.valid;
   assign rsp_in_range  = r_ctl_ff.in_range;
   assign rsp_led_index = r_index_ff;

   `LMX_ASSERT_IMPLY(a_off_display_zero, clock, reset, rsp_valid && !rsp_in_range, rsp_led_index == '0)
   `LMX_ASSERT_IMPLY(a_range_has_beat, clock, reset, rsp_in_range, rsp_valid)
   `LMX_ASSERT_PAST(a_result_delay, clock, reset, rsp_valid, accept, LATENCY)

endmodule

`default_nettype wire
